// ===== rtl/core/mp2_pkg.sv =====
// ============================================================================
// mp2_pkg
// Shared types and constants of the 2x2 stride-2 max pooling block.
// ============================================================================
package mp2_pkg;

    localparam int DATA_BITS     = 16;
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_CHANNELS  = 64;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int STORE_DEPTH   = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int ADDR_BITS     = $clog2(STORE_DEPTH);

    localparam int HEIGHT_BITS   = 11;
    localparam int WIDTH_BITS    = 9;
    localparam int CHAN_BITS     = 7;
    localparam int ROW_CNT_BITS  = 10;
    localparam int COL_CNT_BITS  = 8;
    localparam int CHAN_CNT_BITS = 6;
    localparam int CFG_DATA_BITS = 11;
    localparam int CFG_IDX_BITS  = 2;

    typedef logic signed [DATA_BITS-1:0] t_sample;
    typedef logic [ADDR_BITS-1:0]        t_addr;
    typedef logic [CFG_IDX_BITS-1:0]     t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0]    t_cfg_data;

    localparam t_cfg_idx CFG_IN_HEIGHT = 2'd0;
    localparam t_cfg_idx CFG_IN_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_CHANNELS  = 2'd2;

    typedef enum logic [3:0] {
        OP_DROP  = 4'b0001,
        OP_STORE = 4'b0010,
        OP_MERGE = 4'b0100,
        OP_EMIT  = 4'b1000
    } t_op;

endpackage

// ===== rtl/core/mp2_in_if.sv =====
// ============================================================================
// mp2_in_if
// Input request channel: one feature map element and its start mark.
// ============================================================================
interface mp2_in_if
    import mp2_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    start_of_map;

    modport source (output valid, output sample, output start_of_map, input ready);
    modport sink   (input valid, input sample, input start_of_map, output ready);
endinterface

// ===== rtl/core/mp2_out_if.sv =====
// ============================================================================
// mp2_out_if
// Output request channel: one pooled element and its end-of-map mark.
// ============================================================================
interface mp2_out_if
    import mp2_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample pooled;
    logic    last_of_map;

    modport source (output valid, output pooled, output last_of_map, input ready);
    modport sink   (input valid, input pooled, input last_of_map, output ready);
endinterface

// ===== rtl/core/maxpool_2x2_stride2_top.sv =====
// ============================================================================
// maxpool_2x2_stride2_top
// 2x2 stride-2 max pooling over a feature map streamed in row, column,
// channel order.
//
// Elements arrive on i_in, one request per cycle while i_in.ready allows, and
// pooled results leave on o_out in the same row, column, channel order. A
// request with start_of_map set is taken as row 0, column 0, channel 0. The
// map size is written on the cfg port (height, width, channels) while the
// block is idle; values out of range are saturated, after width and channels
// are cut to their low 9 and 7 bits. A trailing odd row or column is dropped.
// Throughput is one element per cycle while o_out takes results, set by the
// single port pair of the line store, whose read in the accept cycle is
// merged and written back from the merge stage with a one-entry forwarding
// register. When o_out stalls, the output register holds its result and the
// next element that completes a window waits in the merge stage; further
// input is then held off. Reset returns the counters and size registers to
// their defaults (32 x 32, one channel); the line store is not cleared.
// ============================================================================
module maxpool_2x2_stride2_top
    import mp2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mp2_in_if.sink      i_in,
    mp2_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  t_cfg_data   i_cfg_data
);

    logic [HEIGHT_BITS-1:0]   r_h;
    logic [WIDTH_BITS-1:0]    r_w;
    logic [CHAN_BITS-1:0]     r_ch;

    logic [ROW_CNT_BITS-1:0]  r_row;
    logic [COL_CNT_BITS-1:0]  r_col;
    logic [CHAN_CNT_BITS-1:0] r_chan;
    logic [ROW_CNT_BITS-1:0]  n_row;
    logic [COL_CNT_BITS-1:0]  n_col;
    logic [CHAN_CNT_BITS-1:0] n_chan;

    logic [ROW_CNT_BITS-1:0]  cur_row;
    logic [COL_CNT_BITS-1:0]  cur_col;
    logic [CHAN_CNT_BITS-1:0] cur_chan;
    logic [HEIGHT_BITS-1:0]   used_rows;
    logic [WIDTH_BITS-1:0]    used_cols;
    logic [HEIGHT_BITS-1:0]   row_inc;
    logic [WIDTH_BITS-1:0]    col_inc;
    logic [CHAN_BITS-1:0]     chan_inc;
    logic [2*CHAN_BITS-1:0]   col_base;
    logic                     in_range;
    t_addr                    n_addr;
    t_op                      n_op;
    logic                     n_last;
    logic                     in_accept;

    t_sample mem [STORE_DEPTH];
    t_sample r_rd_data;

    logic    r_s1_valid;
    t_op     r_s1_op;
    t_addr   r_s1_addr;
    t_sample r_s1_sample;
    logic    r_s1_last;

    logic    r_wb_valid;
    t_addr   r_wb_addr;
    t_sample r_wb_data;

    logic    r_out_valid;
    t_sample r_out_pooled;
    logic    r_out_last;

    t_sample old_max;
    t_sample merged;
    logic    out_free;
    logic    s1_adv;
    logic    s1_write;

    assign out_free  = !r_out_valid || o_out.ready;
    assign s1_adv    = r_s1_valid && ((r_s1_op != OP_EMIT) || out_free);
    assign s1_write  = s1_adv && (r_s1_op != OP_DROP);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_accept = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.pooled      = r_out_pooled;
    assign o_out.last_of_map = r_out_last;

    always_comb begin
        cur_row   = i_in.start_of_map ? '0 : r_row;
        cur_col   = i_in.start_of_map ? '0 : r_col;
        cur_chan  = i_in.start_of_map ? '0 : r_chan;
        used_rows = {r_h[HEIGHT_BITS-1:1], 1'b0};
        used_cols = {r_w[WIDTH_BITS-1:1], 1'b0};
        in_range  = ({1'b0, cur_row} < used_rows) && ({1'b0, cur_col} < used_cols)
                    && ({1'b0, cur_chan} < r_ch);
        col_base  = {1'b0, cur_col[COL_CNT_BITS-1:1]} * r_ch;
        n_addr    = col_base[ADDR_BITS-1:0] + t_addr'(cur_chan);
        n_last    = ({1'b0, cur_row} == used_rows - 1'b1)
                    && ({1'b0, cur_col} == used_cols - 1'b1)
                    && ({1'b0, cur_chan} == r_ch - 1'b1);
        if (!in_range) begin
            n_op = OP_DROP;
        end else if (!cur_row[0] && !cur_col[0]) begin
            n_op = OP_STORE;
        end else if (cur_row[0] && cur_col[0]) begin
            n_op = OP_EMIT;
        end else begin
            n_op = OP_MERGE;
        end

        chan_inc = {1'b0, cur_chan} + 1'b1;
        col_inc  = {1'b0, cur_col} + 1'b1;
        row_inc  = {1'b0, cur_row} + 1'b1;
        n_row    = cur_row;
        n_col    = cur_col;
        n_chan   = chan_inc[CHAN_CNT_BITS-1:0];
        if (chan_inc >= r_ch) begin
            n_chan = '0;
            n_col  = col_inc[COL_CNT_BITS-1:0];
            if (col_inc >= r_w) begin
                n_col = '0;
                n_row = row_inc[ROW_CNT_BITS-1:0];
                if (row_inc >= r_h) begin
                    n_row = '0;
                end
            end
        end
    end

    always_comb begin
        old_max = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : r_rd_data;
        unique case (r_s1_op)
            OP_STORE: merged = r_s1_sample;
            OP_MERGE,
            OP_EMIT:  merged = (r_s1_sample > old_max) ? r_s1_sample : old_max;
            default:  merged = old_max;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= HEIGHT_BITS'(32);
            r_w <= WIDTH_BITS'(32);
            r_ch <= CHAN_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_HEIGHT: begin
                    if (i_cfg_data < 11'd2) begin
                        r_h <= 11'd2;
                    end else if (i_cfg_data > HEIGHT_BITS'(HEIGHT_LIMIT)) begin
                        r_h <= HEIGHT_BITS'(HEIGHT_LIMIT);
                    end else begin
                        r_h <= i_cfg_data;
                    end
                end
                CFG_IN_WIDTH: begin
                    if (i_cfg_data[WIDTH_BITS-1:0] < 9'd2) begin
                        r_w <= 9'd2;
                    end else if (i_cfg_data[WIDTH_BITS-1:0] > WIDTH_BITS'(MAX_WIDTH)) begin
                        r_w <= WIDTH_BITS'(MAX_WIDTH);
                    end else begin
                        r_w <= i_cfg_data[WIDTH_BITS-1:0];
                    end
                end
                CFG_CHANNELS: begin
                    if (i_cfg_data[CHAN_BITS-1:0] < 7'd1) begin
                        r_ch <= 7'd1;
                    end else if (i_cfg_data[CHAN_BITS-1:0] > CHAN_BITS'(MAX_CHANNELS)) begin
                        r_ch <= CHAN_BITS'(MAX_CHANNELS);
                    end else begin
                        r_ch <= i_cfg_data[CHAN_BITS-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_chan      <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_op     <= OP_DROP;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_chan  <= n_chan;
                r_s1_op <= n_op;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_write) begin
                r_wb_valid <= 1'b1;
            end
            if (s1_adv && (r_s1_op == OP_EMIT)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data   <= mem[n_addr];
            r_s1_addr   <= n_addr;
            r_s1_sample <= i_in.sample;
            r_s1_last   <= n_last;
        end
        if (s1_write) begin
            mem[r_s1_addr] <= merged;
            r_wb_addr      <= r_s1_addr;
            r_wb_data      <= merged;
        end
        if (s1_adv && (r_s1_op == OP_EMIT)) begin
            r_out_pooled <= merged;
            r_out_last   <= r_s1_last;
        end
    end

endmodule

// ===== test/maxpool_2x2_stride2_top_test.sv =====
// ============================================================================
// maxpool_2x2_stride2_top_test
// Self-checking test of the 2x2 stride-2 max pooling block.
//
// A tracker class follows the map position, the line store of running maxima
// and the map size registers, and queues the pooled value and end-of-map mark
// that each accepted element causes. Every result taken from the output is
// compared against the oldest queued value. A short directed part covers odd
// sizes, sample extremes, map wrap and start marks; then random maps are sent
// over many map sizes, saturated register values among them, with random
// stalls on both request channels.
// ============================================================================
module maxpool_2x2_stride2_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mp2_pkg::*;

    typedef struct packed {
        t_sample pooled;
        logic    last_of_map;
    } t_pool_result;

    class window_max_tracker;
        logic [HEIGHT_BITS-1:0] height_reg = 11'd32;
        logic [WIDTH_BITS-1:0]  width_reg  = 9'd32;
        logic [CHAN_BITS-1:0]   chan_reg   = 7'd1;
        int      row_pos;
        int      col_pos;
        int      chan_pos;
        t_sample line_max [STORE_DEPTH];
        bit      line_written [STORE_DEPTH];
        t_pool_result due_pooled [$];
        int      errors;

        function int clamp(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void dims(output int h, output int w, output int c);
            h = clamp(int'(height_reg), 2, HEIGHT_LIMIT);
            w = clamp(int'(width_reg), 2, MAX_WIDTH);
            c = clamp(int'(chan_reg), 1, MAX_CHANNELS);
        endfunction

        function void set_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                CFG_IN_HEIGHT: height_reg = data;
                CFG_IN_WIDTH:  width_reg  = data[WIDTH_BITS-1:0];
                CFG_CHANNELS:  chan_reg   = data[CHAN_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int map_elements();
            int h, w, c;
            dims(h, w, c);
            return h * w * c;
        endfunction

        function bit at_origin();
            return row_pos == 0 && col_pos == 0 && chan_pos == 0;
        endfunction

        function bit reads_unwritten(logic start);
            int h, w, c, r, col, ch;
            dims(h, w, c);
            r   = start ? 0 : row_pos;
            col = start ? 0 : col_pos;
            ch  = start ? 0 : chan_pos;
            if (r >= (h & ~1) || col >= (w & ~1) || ch >= c) return 1'b0;
            if (r % 2 == 0 && col % 2 == 0) return 1'b0;
            return !line_written[(col / 2) * c + ch];
        endfunction

        function void take_element(t_sample s, logic start);
            int h, w, c, used_rows, used_cols, idx;
            t_sample m;
            t_pool_result res;
            dims(h, w, c);
            used_rows = h & ~1;
            used_cols = w & ~1;
            if (start) begin
                row_pos  = 0;
                col_pos  = 0;
                chan_pos = 0;
            end
            if (row_pos < used_rows && col_pos < used_cols && chan_pos < c) begin
                idx = (col_pos / 2) * c + chan_pos;
                if (row_pos % 2 == 0 && col_pos % 2 == 0) begin
                    line_max[idx]     = s;
                    line_written[idx] = 1'b1;
                end else begin
                    m = line_max[idx];
                    if (s > m) m = s;
                    line_max[idx] = m;
                    if (row_pos % 2 == 1 && col_pos % 2 == 1) begin
                        res.pooled      = m;
                        res.last_of_map = (row_pos == used_rows - 1) &&
                                          (col_pos == used_cols - 1) &&
                                          (chan_pos == c - 1);
                        due_pooled.push_back(res);
                    end
                end
            end
            chan_pos++;
            if (chan_pos >= c) begin
                chan_pos = 0;
                col_pos++;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= h) row_pos = 0;
                end
            end
        endfunction

        function void check_pooled(t_sample pooled, logic last);
            t_pool_result exp_r;
            if (due_pooled.size() == 0) begin
                $display("%0t: pooled result %0d with none expected", $time, pooled);
                errors++;
                return;
            end
            exp_r = due_pooled.pop_front();
            if (pooled !== exp_r.pooled) begin
                $display("%0t: pooled expected %0d, actual %0d",
                         $time, exp_r.pooled, pooled);
                errors++;
            end
            if (last !== exp_r.last_of_map) begin
                $display("%0t: last_of_map expected %0b, actual %0b",
                         $time, exp_r.last_of_map, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_pooled.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    mp2_in_if  in_req ();
    mp2_out_if out_res ();

    window_max_tracker tracker = new();

    bit in_burst;
    bit out_burst;
    int sent_elements;

    t_sample odd_map [9] = '{16'sh8000, -16'sd1, 16'sd5,
                             16'sh8000, -16'sd2, 16'sd7,
                             16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    t_sample two_chan_map [8] = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sh8000,
                                  -16'sd1, 16'sh8001, 16'sd1, 16'sh8000};

    t_cfg_data edge_height [7] = '{11'd0, 11'd2047, 11'd1024, 11'd2, 11'd2, 11'd5, 11'd1};
    t_cfg_data edge_width  [7] = '{11'd0, 11'd511, 11'd256, 11'd256, 11'd2, 11'd255, 11'd1};
    t_cfg_data edge_chans  [7] = '{11'd0, 11'd127, 11'd64, 11'd1, 11'd64, 11'd63, 11'd1};

    maxpool_2x2_stride2_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_req),
        .o_out      (out_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_element(t_sample s, logic start);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            in_req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_req.valid        <= 1'b1;
        in_req.sample       <= s;
        in_req.start_of_map <= start;
        @(posedge i_clk);
        while (!in_req.ready) @(posedge i_clk);
        tracker.take_element(s, start);
        sent_elements++;
    endtask

    task automatic wait_idle();
        in_req.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_map_size(t_cfg_data h, t_cfg_data w, t_cfg_data c);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IN_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        tracker.set_reg(CFG_IN_HEIGHT, h);
        i_cfg_idx  <= CFG_IN_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        tracker.set_reg(CFG_IN_WIDTH, w);
        i_cfg_idx  <= CFG_CHANNELS;
        i_cfg_data <= c;
        @(posedge i_clk);
        tracker.set_reg(CFG_CHANNELS, c);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_sample random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return t_sample'($urandom);
        endcase
    endfunction

    initial begin : result_sink
        int gap;
        out_res.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = out_burst ? 0 : $urandom_range(0, 11);
            if (gap != 0) begin
                out_res.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_res.ready <= 1'b1;
            do @(posedge i_clk); while (!out_res.valid);
            tracker.check_pooled(out_res.pooled, out_res.last_of_map);
        end
    end

    initial begin : stimulus
        int n, map, pick;
        bit noisy, first;
        logic start;
        t_cfg_data h, w, c;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_IN_HEIGHT;
        i_cfg_data          <= '0;
        in_req.valid        <= 1'b0;
        in_req.sample       <= '0;
        in_req.start_of_map <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_map_size(11'd3, 11'd3, 11'd1);
        foreach (odd_map[i]) send_element(odd_map[i], i == 0);
        wait_idle();
        write_map_size(11'd2, 11'd2, 11'd2);
        foreach (two_chan_map[i]) send_element(two_chan_map[i], i == 0);
        for (int i = 0; i < 11; i++) begin
            send_element(random_sample(), i == 3);
        end
        wait_idle();

        while (sent_elements < 1300) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                pick = $urandom_range(0, 6);
                h = edge_height[pick];
                w = edge_width[pick];
                c = edge_chans[pick];
            end else begin
                h = t_cfg_data'($urandom_range(2, 9));
                w = t_cfg_data'($urandom_range(2, 11));
                c = t_cfg_data'($urandom_range(1, 5));
            end
            write_map_size(h, w, c);
            map = tracker.map_elements();
            n = map * $urandom_range(1, 3);
            if (n > 600) n = (map <= 600) ? map : $urandom_range(100, 400);
            if (n > 1300 - sent_elements) n = 1300 - sent_elements;
            noisy     = $urandom_range(0, 3) == 0;
            in_burst  = $urandom_range(0, 3) == 0;
            out_burst = $urandom_range(0, 3) == 0;
            first     = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (first) start = $urandom_range(0, 3) != 0;
                else if (noisy) start = $urandom_range(0, 47) == 0;
                else start = tracker.at_origin() && $urandom_range(0, 1);
                if (tracker.reads_unwritten(start)) start = 1'b1;
                first = 1'b0;
                send_element(random_sample(), start);
            end
            wait_idle();
        end

        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : run_limit
        #5_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
